>>> design/sprite_entry_row_expander_top_assert.svh
// ----------------------------------------------------------------------------
// Sprite entry row expander: assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet while rst is high.
// ----------------------------------------------------------------------------
`ifndef SPRITE_ENTRY_ROW_EXPANDER_TOP_ASSERT_SVH
`define SPRITE_ENTRY_ROW_EXPANDER_TOP_ASSERT_SVH

// Condition holds at every edge out of reset
`define SERE_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next
`define SERE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/sere_pkg.sv
// ----------------------------------------------------------------------------
// sere_pkg
// Types and constants shared by the sprite entry row expander modules.
// ----------------------------------------------------------------------------
package sere_pkg;

  // Entry queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = 1;

  // Copies per row: (x,y), (x-512,y), (x,y+512), (x-512,y+512)
  localparam logic [1:0]  LAST_COPY    = 2'd3;
  localparam logic [10:0] WRAP_OFFSET  = 11'h200;
  localparam logic [10:0] Y_ORIGIN     = 11'h100;
  localparam logic [6:0]  PAL_MASK     = 7'h3e;
  localparam logic [6:0]  PAL_HOLE_FIX = 7'h60;
  localparam logic [7:0]  ROW_PITCH    = 8'd16;

  // Decoded sprite entry as held in the queue
  typedef struct packed {
    logic [15:0]        tile;
    logic [2:0]         rows_m1;
    logic               flip_x;
    logic               flip_y;
    logic               high_priority;
    logic [6:0]         palette;
    logic [9:0]         x_base;   // raw x + 1, 1..512
    logic signed [10:0] y_base;   // 256 - raw y
  } entry_t;

endpackage

>>> design/sere_front.sv
// ----------------------------------------------------------------------------
// sere_front
// Accepts sprite list words, drops disabled entries and decodes the rest.
// ----------------------------------------------------------------------------
module sere_front
  import sere_pkg::*;
(
  input  logic       start,
  input  logic       busy,
  input  logic [7:0] attr_control,
  input  logic [7:0] y_low,
  input  logic [7:0] tile_high,
  input  logic [7:0] tile_low,
  input  logic [6:0] attr_colour,
  input  logic [7:0] x_low,
  output logic       push,
  output entry_t     entry
);

  logic [6:0] pal_raw;

  // Only enabled entries go to the queue
  assign push = start && !busy && attr_control[2];

  // Palette with the hole skipped
  assign pal_raw = attr_colour & PAL_MASK;

  always_comb begin
    entry.tile          = {tile_high, tile_low};
    entry.rows_m1       = attr_control[7:5];
    entry.flip_x        = attr_control[4];
    entry.flip_y        = attr_control[3];
    entry.high_priority = attr_colour[6];
    entry.palette       = pal_raw[5] ? (pal_raw ^ PAL_HOLE_FIX) : pal_raw;
    entry.x_base        = {1'b0, attr_colour[0], x_low} + 10'd1;
    entry.y_base        = Y_ORIGIN - {1'b0, attr_control[1:0], y_low};
  end

endmodule

>>> design/sere_queue.sv
// ----------------------------------------------------------------------------
// sere_queue
// Short FIFO of decoded entries between the front and the back.
// ----------------------------------------------------------------------------
module sere_queue
  import sere_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  entry_t            push_entry,
  input  logic              pop,
  output entry_t            head,
  output logic              empty,
  output logic              full,
  output logic [QUEUE_AW:0] count
);

  entry_t              slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;

  localparam logic [QUEUE_AW-1:0] PTR_MAX   = QUEUE_AW'(QUEUE_DEPTH - 1);
  localparam logic [QUEUE_AW:0]   COUNT_MAX = (QUEUE_AW + 1)'(QUEUE_DEPTH);

  assign empty = (count == '0);
  assign full  = (count == COUNT_MAX);
  assign head  = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_MAX) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_MAX) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> design/sere_back.sv
// ----------------------------------------------------------------------------
// sere_back
// Walks rows and wrap copies of the head entry, one registered command a cycle while the head is valid.
// ----------------------------------------------------------------------------
module sere_back
  import sere_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  entry_t             head,
  input  logic               head_valid,
  output logic               pop,
  output logic               strobe,
  output logic [16:0]        tile_code,
  output logic signed [10:0] pos_x,
  output logic signed [10:0] pos_y,
  output logic               flip_x,
  output logic               flip_y,
  output logic [6:0]         palette,
  output logic               high_priority,
  output logic               last
);

  logic [2:0]  row;
  logic [1:0]  copy;
  logic        row_done;
  logic        entry_done;
  logic [7:0]  row_drop;
  logic [10:0] x_copy;
  logic [10:0] y_row;

  assign row_done   = (copy == LAST_COPY);
  assign entry_done = row_done && (row == head.rows_m1);
  assign pop        = head_valid && entry_done;

  // Position of this copy
  assign row_drop = ({5'd0, row} + 8'd1) * ROW_PITCH;
  assign x_copy   = copy[0] ? (11'(head.x_base) - WRAP_OFFSET) : 11'(head.x_base);
  assign y_row    = head.y_base - 11'(row_drop) + (copy[1] ? WRAP_OFFSET : 11'd0);

  // Row / copy counters
  always_ff @(posedge clk) begin
    if (rst) begin
      row  <= '0;
      copy <= '0;
    end else if (head_valid) begin
      copy <= copy + 1'b1;
      if (entry_done) begin
        row <= '0;
      end else if (row_done) begin
        row <= row + 1'b1;
      end
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (head_valid) begin
      tile_code     <= {1'b0, head.tile} + {14'd0, row};
      pos_x         <= x_copy;
      pos_y         <= y_row;
      flip_x        <= head.flip_x;
      flip_y        <= head.flip_y;
      palette       <= head.palette;
      high_priority <= head.high_priority;
      last          <= entry_done;
    end
  end

endmodule

>>> design/sprite_entry_row_expander_top.sv
// An accepted word is written into the entry queue; the back end expands its head
// entry into registered commands, one per cycle while the queue is not empty. An
// enabled H-row entry gives 4*H commands (up to 32); a disabled one gives none.
// busy rises only when the two-entry queue is full; commands carry no stall.
// Reset (rst, synchronous) empties the queue and clears the row/copy counters.
// ----------------------------------------------------------------------------
// sprite_entry_row_expander_top
// Expands sprite list entries into per-row, per-wrap-copy draw commands.
// ----------------------------------------------------------------------------
module sprite_entry_row_expander_top
  import sere_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         attr_control,
  input  logic [7:0]         y_low,
  input  logic [7:0]         tile_high,
  input  logic [7:0]         tile_low,
  input  logic [6:0]         attr_colour,
  input  logic [7:0]         x_low,
  output logic               strobe,
  output logic [16:0]        tile_code,
  output logic signed [10:0] pos_x,
  output logic signed [10:0] pos_y,
  output logic               flip_x,
  output logic               flip_y,
  output logic [6:0]         palette,
  output logic               high_priority,
  output logic               last
);

  logic              push;
  entry_t            push_entry;
  logic              pop;
  entry_t            head;
  logic              q_empty;
  logic              q_full;
  logic [QUEUE_AW:0] q_count;

  assign busy = q_full;

  // Front: accept and classify
  sere_front u_front (
    .start        (start),
    .busy         (busy),
    .attr_control (attr_control),
    .y_low        (y_low),
    .tile_high    (tile_high),
    .tile_low     (tile_low),
    .attr_colour  (attr_colour),
    .x_low        (x_low),
    .push         (push),
    .entry        (push_entry)
  );

  // Entry queue
  sere_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full),
    .count      (q_count)
  );

  // Back: command expansion
  sere_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .head_valid    (!q_empty),
    .pop           (pop),
    .strobe        (strobe),
    .tile_code     (tile_code),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .flip_x        (flip_x),
    .flip_y        (flip_y),
    .palette       (palette),
    .high_priority (high_priority),
    .last          (last)
  );

  // Checks
`include "sprite_entry_row_expander_top_assert.svh"

  `SERE_ASSERT_ALWAYS(a_count_bound, q_count <= (QUEUE_AW + 1)'(QUEUE_DEPTH), "queue overfilled")
  `SERE_ASSERT_NEXT(a_emit_when_queued, !q_empty, strobe, "queued entry not expanded")
  `SERE_ASSERT_NEXT(a_no_idle_emit, q_empty, !strobe, "command without a queued entry")
  `SERE_ASSERT_NEXT(a_entry_contiguous, strobe && !last, strobe, "entry commands interrupted")

endmodule
